### sv/echo_reply_tracker_top_macros.svh
// Assertion macros shared by the echo reply tracker RTL.
`ifndef ECHO_REPLY_TRACKER_TOP_MACROS_SVH
`define ECHO_REPLY_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ERT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ERT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ert_pkg.sv
// Package: widths, codes and shared types of the echo reply tracker.
`default_nettype none

package ert_pkg;

  // Seen bitmap depth; must be a power of two (slot is the low sequence bits).
  localparam int SEEN_DEPTH = 1024;
  localparam int SEEN_AW    = $clog2(SEEN_DEPTH);

  localparam int LEN_W   = 16;
  localparam int SEQ_W   = 16;
  localparam int KIND_W  = 8;
  localparam int SEC_W   = 32;
  localparam int USEC_W  = 20;
  localparam int CNT_W   = 32;
  localparam int TIME_W  = 32;
  localparam int SUM_W   = 48;
  localparam int DEN_W   = CNT_W + 1;
  localparam int STAT_W  = 3;
  localparam int REQ_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Divider walks one quotient bit per cycle.
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [TIME_W-1:0] USEC_PER_SEC = 32'd1000000;
  localparam logic [TIME_W-1:0] NO_AVERAGE   = 32'h0FFF_FFFF;
  localparam logic [LEN_W:0]    ICMP_HDR_LEN = 17'd8;

  // Request types
  localparam logic [REQ_W-1:0] REQ_SEND   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REPLY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

  // ICMP types
  localparam logic [KIND_W-1:0] KIND_ECHO_REPLY   = 8'd0;
  localparam logic [KIND_W-1:0] KIND_ECHO_REQUEST = 8'd8;

  // Result status
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;  // sent, or report
  localparam logic [STAT_W-1:0] ST_SHORT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FOREIGN  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NEW      = 3'd3;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd4;
  localparam logic [STAT_W-1:0] ST_OWN_REQ  = 3'd5;
  localparam logic [STAT_W-1:0] ST_OTHER    = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN = 1'd1;

  localparam logic [CFG_DATA_W-1:0] PAYLOAD_LEN_RST = 16'd56;

  // Access to the seen bitmap; read and write never in the same cycle.
  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic               wr_bit;
    logic [SEEN_AW-1:0] addr;
  } seen_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### sv/ert_seen.sv
// Seen bitmap memory with a clearing pass after reset.
`default_nettype none

module ert_seen (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire ert_pkg::seen_req_t req_i,
  output logic                    rd_bit_o,
  output logic                    clr_done_o
);

  logic                       seen_mem_r [ert_pkg::SEEN_DEPTH];
  logic                       rd_bit_r;
  logic                       clr_busy_r, clr_busy_nxt;
  logic [ert_pkg::SEEN_AW-1:0] clr_idx_r, clr_idx_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == ert_pkg::SEEN_AW'(ert_pkg::SEEN_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      seen_mem_r[clr_idx_r] <= 1'b0;
    end else if (req_i.wr_en) begin
      seen_mem_r[req_i.addr] <= req_i.wr_bit;
    end
    if (req_i.rd_en) begin
      rd_bit_r <= seen_mem_r[req_i.addr];
    end
  end

  assign rd_bit_o   = rd_bit_r;
  assign clr_done_o = !clr_busy_r;

endmodule

`default_nettype wire

### sv/ert_div.sv
// Restoring divider: 48-bit trip sum over 33-bit count, one bit per cycle.
`default_nettype none

`include "echo_reply_tracker_top_macros.svh"

module ert_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start_i,
  input  wire  [ert_pkg::SUM_W-1:0]    dividend_i,
  input  wire  [ert_pkg::DEN_W-1:0]    divisor_i,
  output logic [ert_pkg::SUM_W-1:0]    quotient_o,
  output ert_pkg::div_stat_t           stat_o
);

  logic [ert_pkg::SUM_W-1:0]     quo_r, quo_nxt;
  logic [ert_pkg::DEN_W-1:0]     rem_r, rem_nxt;
  logic [ert_pkg::DEN_W-1:0]     den_r, den_nxt;
  logic [ert_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [ert_pkg::DEN_W:0]       rem_sh;
  logic [ert_pkg::DEN_W+1:0]     diff;
  logic                          ge;

  // shared subtractor: shifted remainder minus divisor
  assign rem_sh = {rem_r, quo_r[ert_pkg::SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = !diff[ert_pkg::DEN_W+1];

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      rem_nxt = ge ? diff[ert_pkg::DEN_W-1:0] : rem_sh[ert_pkg::DEN_W-1:0];
      quo_nxt = {quo_r[ert_pkg::SUM_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end else if (start_i) begin
      quo_nxt  = dividend_i;
      rem_nxt  = '0;
      den_nxt  = divisor_i;
      cnt_nxt  = ert_pkg::DIV_CNT_W'(ert_pkg::DIV_STEPS - 1);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quotient_o  = quo_r;
  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;

  `ERT_ASSERT_NOW(a_div_rem_below_den, busy_r, rem_r < den_r, "divider remainder not below divisor")
  `ERT_ASSERT_NEXT(a_div_start_runs, start_i && !busy_r, busy_r, "divider start did not run")
  `ERT_ASSERT_NOW(a_div_done_idle, done_r, !busy_r, "divider done while still busy")

endmodule

`default_nettype wire

### sv/echo_reply_tracker_top.sv
// Top level: echo reply tracker sequencer, counters and result register.
// From accept to out_valid: a send, a dropped reply or an empty report goes to S_DONE; an echo reply
// takes its diff at accept, then multiply, add, update (S_MUL, S_ADD, S_UPD); a report average runs
// S_DIV. S_DONE loads the result register once it is free. One item at a time; the report's 48-step
// divider makes the average the longest item. Sync active-low reset clears counters, resets config,
// then a pass clears the seen bitmap; in_ready stays low during that pass while config writes are still taken.
`default_nettype none

`include "echo_reply_tracker_top_macros.svh"

module echo_reply_tracker_top (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration
  input  wire                                 cfg_we,
  input  wire  [ert_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [ert_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // request beat
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [ert_pkg::REQ_W-1:0]           in_req_type,
  input  wire  [ert_pkg::LEN_W-1:0]           in_reply_length,
  input  wire  [ert_pkg::LEN_W-1:0]           in_reply_id,
  input  wire  [ert_pkg::KIND_W-1:0]          in_reply_kind,
  input  wire  [ert_pkg::SEQ_W-1:0]           in_reply_seq,
  input  wire  [ert_pkg::SEC_W-1:0]           in_sent_sec,
  input  wire  [ert_pkg::USEC_W-1:0]          in_sent_usec,
  input  wire  [ert_pkg::SEC_W-1:0]           in_now_sec,
  input  wire  [ert_pkg::USEC_W-1:0]          in_now_usec,
  // result beat
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [ert_pkg::STAT_W-1:0]          out_status,
  output logic [ert_pkg::SEQ_W-1:0]           out_seq_out,
  output logic [ert_pkg::TIME_W-1:0]          out_trip_time,
  output logic [ert_pkg::CNT_W-1:0]           out_sent_total,
  output logic [ert_pkg::CNT_W-1:0]           out_received_total,
  output logic [ert_pkg::CNT_W-1:0]           out_duplicate_total,
  output logic [ert_pkg::TIME_W-1:0]          out_min_time,
  output logic [ert_pkg::TIME_W-1:0]          out_max_time,
  output logic [ert_pkg::TIME_W-1:0]          out_avg_time
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;  // seconds times 1e6
  localparam logic [2:0] S_ADD  = 3'd2;  // plus microseconds
  localparam logic [2:0] S_UPD  = 3'd3;  // stats and seen bitmap
  localparam logic [2:0] S_DIV  = 3'd4;  // report average
  localparam logic [2:0] S_DONE = 3'd5;  // wait for result register

  logic [2:0] state_r, state_nxt;

  // config
  logic [ert_pkg::CFG_DATA_W-1:0] own_id_r, own_id_nxt;
  logic [ert_pkg::CFG_DATA_W-1:0] pay_len_r, pay_len_nxt;

  // running statistics
  logic [ert_pkg::CNT_W-1:0]  sent_cnt_r, sent_cnt_nxt;
  logic [ert_pkg::CNT_W-1:0]  recv_cnt_r, recv_cnt_nxt;
  logic [ert_pkg::CNT_W-1:0]  dup_cnt_r, dup_cnt_nxt;
  logic [ert_pkg::TIME_W-1:0] least_r, least_nxt;
  logic [ert_pkg::TIME_W-1:0] most_r, most_nxt;
  logic [ert_pkg::SUM_W-1:0]  sum_r, sum_nxt;

  // per-item working registers
  logic [ert_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [ert_pkg::SEQ_W-1:0]  seq_r, seq_nxt;
  logic [ert_pkg::TIME_W-1:0] secs_r, secs_nxt;
  logic [ert_pkg::TIME_W-1:0] usecs_r, usecs_nxt;
  logic [ert_pkg::TIME_W-1:0] prod_r, prod_nxt;
  logic [ert_pkg::TIME_W-1:0] trip_r, trip_nxt;
  logic [ert_pkg::TIME_W-1:0] avg_r, avg_nxt;

  // result register
  logic                       out_valid_r, out_valid_nxt;
  logic [ert_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [ert_pkg::SEQ_W-1:0]  out_seq_r, out_seq_nxt;
  logic [ert_pkg::TIME_W-1:0] out_trip_r, out_trip_nxt;
  logic [ert_pkg::CNT_W-1:0]  out_sent_r, out_sent_nxt;
  logic [ert_pkg::CNT_W-1:0]  out_recv_r, out_recv_nxt;
  logic [ert_pkg::CNT_W-1:0]  out_dup_r, out_dup_nxt;
  logic [ert_pkg::TIME_W-1:0] out_min_r, out_min_nxt;
  logic [ert_pkg::TIME_W-1:0] out_max_r, out_max_nxt;
  logic [ert_pkg::TIME_W-1:0] out_avg_r, out_avg_nxt;

  // helpers
  logic                       in_acc;
  logic                       clr_done;
  logic                       seen_bit;
  logic                       too_short;
  logic                       usec_borrow;
  logic [ert_pkg::TIME_W-1:0] usec_diff;
  logic [ert_pkg::SUM_W:0]    sum_ext;
  logic                       res_load;
  ert_pkg::seen_req_t         seen_req;
  logic                       div_start;
  logic [ert_pkg::DEN_W-1:0]  div_den;
  logic [ert_pkg::SUM_W-1:0]  div_quo;
  ert_pkg::div_stat_t         div_stat;

  ert_seen u_seen (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (seen_req),
    .rd_bit_o  (seen_bit),
    .clr_done_o(clr_done)
  );

  ert_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (div_start),
    .dividend_i(sum_r),
    .divisor_i (div_den),
    .quotient_o(div_quo),
    .stat_o    (div_stat)
  );

  assign in_ready = (state_r == S_IDLE) && clr_done;
  assign in_acc   = in_valid && in_ready;

  // length test at 17 bits: a large payload_len drops everything
  assign too_short = {1'b0, in_reply_length} < ({1'b0, pay_len_r} + ert_pkg::ICMP_HDR_LEN);

  // microsecond borrow; all trip math wraps at 32 bits
  assign usec_borrow = in_now_usec < in_sent_usec;
  assign usec_diff   = {12'd0, in_now_usec} - {12'd0, in_sent_usec};

  assign sum_ext  = {1'b0, sum_r} + {{(ert_pkg::SUM_W + 1 - ert_pkg::TIME_W){1'b0}}, trip_r};
  assign div_den  = {1'b0, recv_cnt_r} + {1'b0, dup_cnt_r};
  assign res_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // config writes
  always_comb begin
    own_id_nxt  = own_id_r;
    pay_len_nxt = pay_len_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ert_pkg::CFG_OWN_ID:      own_id_nxt  = cfg_wdata;
        ert_pkg::CFG_PAYLOAD_LEN: pay_len_nxt = cfg_wdata;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    sent_cnt_nxt = sent_cnt_r;
    recv_cnt_nxt = recv_cnt_r;
    dup_cnt_nxt  = dup_cnt_r;
    least_nxt    = least_r;
    most_nxt     = most_r;
    sum_nxt      = sum_r;
    status_nxt   = status_r;
    seq_nxt      = seq_r;
    secs_nxt     = secs_r;
    usecs_nxt    = usecs_r;
    prod_nxt     = prod_r;
    trip_nxt     = trip_r;
    avg_nxt      = avg_r;
    seen_req     = '0;
    div_start    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt = ert_pkg::ST_OK;
          seq_nxt    = '0;
          trip_nxt   = '0;
          avg_nxt    = '0;
          unique case (in_req_type)
            ert_pkg::REQ_SEND: begin
              seq_nxt         = sent_cnt_r[ert_pkg::SEQ_W-1:0];
              sent_cnt_nxt    = sent_cnt_r + 1'b1;
              seen_req.wr_en  = 1'b1;
              seen_req.wr_bit = 1'b0;
              seen_req.addr   = sent_cnt_r[ert_pkg::SEEN_AW-1:0];
              state_nxt       = S_DONE;
            end
            ert_pkg::REQ_REPLY: begin
              seq_nxt   = in_reply_seq;
              state_nxt = S_DONE;
              priority if (too_short) begin
                status_nxt = ert_pkg::ST_SHORT;
              end else if (in_reply_id != own_id_r) begin
                status_nxt = ert_pkg::ST_FOREIGN;
              end else if (in_reply_kind == ert_pkg::KIND_ECHO_REPLY) begin
                secs_nxt  = in_now_sec - in_sent_sec - {31'd0, usec_borrow};
                usecs_nxt = usec_diff + (usec_borrow ? ert_pkg::USEC_PER_SEC : '0);
                // fetch the seen bit now; used in S_UPD
                seen_req.rd_en = 1'b1;
                seen_req.addr  = in_reply_seq[ert_pkg::SEEN_AW-1:0];
                state_nxt      = S_MUL;
              end else if (in_reply_kind == ert_pkg::KIND_ECHO_REQUEST) begin
                status_nxt = ert_pkg::ST_OWN_REQ;
              end else begin
                status_nxt = ert_pkg::ST_OTHER;
              end
            end
            ert_pkg::REQ_REPORT: begin
              if (recv_cnt_r == '0) begin
                avg_nxt   = ert_pkg::NO_AVERAGE;
                state_nxt = S_DONE;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            ert_pkg::REQ_NONE: begin
              // no result
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = ert_pkg::TIME_W'(secs_r * ert_pkg::USEC_PER_SEC);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        trip_nxt  = prod_r + usecs_r;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        sum_nxt = sum_ext[ert_pkg::SUM_W] ? '1 : sum_ext[ert_pkg::SUM_W-1:0];
        if (trip_r < least_r) begin
          least_nxt = trip_r;
        end
        if (trip_r > most_r) begin
          most_nxt = trip_r;
        end
        if (seen_bit) begin
          dup_cnt_nxt = dup_cnt_r + 1'b1;
          status_nxt  = ert_pkg::ST_DUP;
        end else begin
          recv_cnt_nxt    = recv_cnt_r + 1'b1;
          status_nxt      = ert_pkg::ST_NEW;
          seen_req.wr_en  = 1'b1;
          seen_req.wr_bit = 1'b1;
          seen_req.addr   = seq_r[ert_pkg::SEEN_AW-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DIV: begin
        if (div_stat.done) begin
          // quotient above 32 bits saturates
          avg_nxt   = (|div_quo[ert_pkg::SUM_W-1:ert_pkg::TIME_W]) ? '1
                                                                  : div_quo[ert_pkg::TIME_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register: holds a finished beat until the sink takes it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_seq_nxt    = out_seq_r;
    out_trip_nxt   = out_trip_r;
    out_sent_nxt   = out_sent_r;
    out_recv_nxt   = out_recv_r;
    out_dup_nxt    = out_dup_r;
    out_min_nxt    = out_min_r;
    out_max_nxt    = out_max_r;
    out_avg_nxt    = out_avg_r;
    if (res_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_seq_nxt    = seq_r;
      out_trip_nxt   = trip_r;
      out_sent_nxt   = sent_cnt_r;
      out_recv_nxt   = recv_cnt_r;
      out_dup_nxt    = dup_cnt_r;
      out_min_nxt    = least_r;
      out_max_nxt    = most_r;
      out_avg_nxt    = avg_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      own_id_r    <= '0;
      pay_len_r   <= ert_pkg::PAYLOAD_LEN_RST;
      sent_cnt_r  <= '0;
      recv_cnt_r  <= '0;
      dup_cnt_r   <= '0;
      least_r     <= '1;
      most_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      own_id_r    <= own_id_nxt;
      pay_len_r   <= pay_len_nxt;
      sent_cnt_r  <= sent_cnt_nxt;
      recv_cnt_r  <= recv_cnt_nxt;
      dup_cnt_r   <= dup_cnt_nxt;
      least_r     <= least_nxt;
      most_r      <= most_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    seq_r        <= seq_nxt;
    secs_r       <= secs_nxt;
    usecs_r      <= usecs_nxt;
    prod_r       <= prod_nxt;
    trip_r       <= trip_nxt;
    avg_r        <= avg_nxt;
    out_status_r <= out_status_nxt;
    out_seq_r    <= out_seq_nxt;
    out_trip_r   <= out_trip_nxt;
    out_sent_r   <= out_sent_nxt;
    out_recv_r   <= out_recv_nxt;
    out_dup_r    <= out_dup_nxt;
    out_min_r    <= out_min_nxt;
    out_max_r    <= out_max_nxt;
    out_avg_r    <= out_avg_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_seq_out         = out_seq_r;
  assign out_trip_time       = out_trip_r;
  assign out_sent_total      = out_sent_r;
  assign out_received_total  = out_recv_r;
  assign out_duplicate_total = out_dup_r;
  assign out_min_time        = out_min_r;
  assign out_max_time        = out_max_r;
  assign out_avg_time        = out_avg_r;

  `ERT_ASSERT_NOW(a_no_accept_while_clearing, in_valid && in_ready, clr_done, "beat taken during bitmap clear")
  `ERT_ASSERT_NEXT(a_recv_only_in_update, state_r != S_UPD, $stable(recv_cnt_r), "receive count moved outside update")
  `ERT_ASSERT_NOW(a_min_not_above_max, recv_cnt_r != '0, least_r <= most_r, "min trip above max trip")

endmodule

`default_nettype wire

### bench/echo_reply_tracker_top_tb.sv
// Self-checking bench for the echo reply tracker: random and directed beats, scoreboard checks.
module echo_reply_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest item is a report average; the drain is set to outlast one.
  localparam int DRAIN_CYCLES = 64;
  // Receiver hold-off long enough to back the block up into its input.
  localparam int HOLD_SPAN    = 400;
  // Slowest legal run: ~1200 beats x (longest item + gaps + stalls), clear pass, hold-offs, drains.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [ert_pkg::REQ_W-1:0]  req_type;
    logic [ert_pkg::LEN_W-1:0]  reply_length;
    logic [ert_pkg::LEN_W-1:0]  reply_id;
    logic [ert_pkg::KIND_W-1:0] reply_kind;
    logic [ert_pkg::SEQ_W-1:0]  reply_seq;
    logic [ert_pkg::SEC_W-1:0]  sent_sec;
    logic [ert_pkg::USEC_W-1:0] sent_usec;
    logic [ert_pkg::SEC_W-1:0]  now_sec;
    logic [ert_pkg::USEC_W-1:0] now_usec;
  } req_t;

  typedef struct packed {
    logic [ert_pkg::STAT_W-1:0] status;
    logic [ert_pkg::SEQ_W-1:0]  seq_out;
    logic [ert_pkg::TIME_W-1:0] trip_time;
    logic [ert_pkg::CNT_W-1:0]  sent_total;
    logic [ert_pkg::CNT_W-1:0]  received_total;
    logic [ert_pkg::CNT_W-1:0]  duplicate_total;
    logic [ert_pkg::TIME_W-1:0] min_time;
    logic [ert_pkg::TIME_W-1:0] max_time;
    logic [ert_pkg::TIME_W-1:0] avg_time;
  } tally_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_we = 1'b0;
  logic [ert_pkg::CFG_IDX_W-1:0]  cfg_index = ert_pkg::CFG_OWN_ID;
  logic [ert_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic in_valid = 1'b0;
  logic in_ready;
  req_t offer = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic [ert_pkg::STAT_W-1:0] out_status;
  logic [ert_pkg::SEQ_W-1:0]  out_seq_out;
  logic [ert_pkg::TIME_W-1:0] out_trip_time;
  logic [ert_pkg::CNT_W-1:0]  out_sent_total;
  logic [ert_pkg::CNT_W-1:0]  out_received_total;
  logic [ert_pkg::CNT_W-1:0]  out_duplicate_total;
  logic [ert_pkg::TIME_W-1:0] out_min_time;
  logic [ert_pkg::TIME_W-1:0] out_max_time;
  logic [ert_pkg::TIME_W-1:0] out_avg_time;

  echo_reply_tracker_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (offer.req_type),
    .in_reply_length     (offer.reply_length),
    .in_reply_id         (offer.reply_id),
    .in_reply_kind       (offer.reply_kind),
    .in_reply_seq        (offer.reply_seq),
    .in_sent_sec         (offer.sent_sec),
    .in_sent_usec        (offer.sent_usec),
    .in_now_sec          (offer.now_sec),
    .in_now_usec         (offer.now_usec),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_seq_out         (out_seq_out),
    .out_trip_time       (out_trip_time),
    .out_sent_total      (out_sent_total),
    .out_received_total  (out_received_total),
    .out_duplicate_total (out_duplicate_total),
    .out_min_time        (out_min_time),
    .out_max_time        (out_max_time),
    .out_avg_time        (out_avg_time)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Tracker shadow state: config registers and bookkeeping, updated per accepted beat.
  // ---------------------------------------------------------------------------
  logic [ert_pkg::CFG_DATA_W-1:0] own_ident   = '0;
  logic [ert_pkg::CFG_DATA_W-1:0] min_payload = ert_pkg::PAYLOAD_LEN_RST;

  logic [ert_pkg::CNT_W-1:0]  sends_made  = '0;
  logic [ert_pkg::CNT_W-1:0]  fresh_count = '0;
  logic [ert_pkg::CNT_W-1:0]  dup_count   = '0;
  logic [ert_pkg::TIME_W-1:0] least_us    = '1;
  logic [ert_pkg::TIME_W-1:0] most_us     = '0;
  logic [ert_pkg::SUM_W-1:0]  time_sum    = '0;
  bit                         seen_slots [ert_pkg::SEEN_DEPTH];

  tally_t awaited_tallies [$];
  req_t   pending_requests [$];

  int gen_sends    = 0;   // sends queued so far, keeps generated replies near live sequences
  int idle_pct     = 13;
  int hold_asks    = 0;
  int mismatches   = 0;
  int beats_taken  = 0;
  int results_seen = 0;
  int settings_run = 0;
  int cycles       = 0;
  int status_hits [8];

  // Works out the result of one accepted beat; no result for the unused request type.
  function automatic tally_t tally_request(input req_t r, output bit yields);
    tally_t t;
    logic [ert_pkg::LEN_W:0]    thr;
    logic [ert_pkg::TIME_W-1:0] secs, usecs, trip;
    logic [ert_pkg::SUM_W:0]    wide_sum;
    logic [ert_pkg::CNT_W:0]    den;
    logic [ert_pkg::SUM_W-1:0]  quo;
    int                         slot;
    t = '0;
    yields = 1'b1;
    if (r.req_type == ert_pkg::REQ_NONE) begin
      yields = 1'b0;
      return t;
    end
    if (r.req_type == ert_pkg::REQ_SEND) begin
      t.seq_out = sends_made[ert_pkg::SEQ_W-1:0];
      seen_slots[int'(t.seq_out) % ert_pkg::SEEN_DEPTH] = 1'b0;
      sends_made = sends_made + 1;
      t.status = ert_pkg::ST_OK;
    end else if (r.req_type == ert_pkg::REQ_REPLY) begin
      t.seq_out = r.reply_seq;
      thr = {1'b0, min_payload} + ert_pkg::ICMP_HDR_LEN;
      if ({1'b0, r.reply_length} < thr) begin
        t.status = ert_pkg::ST_SHORT;
      end else if (r.reply_id != own_ident) begin
        t.status = ert_pkg::ST_FOREIGN;
      end else if (r.reply_kind == ert_pkg::KIND_ECHO_REPLY) begin
        secs  = r.now_sec - r.sent_sec;
        usecs = {12'b0, r.now_usec} - {12'b0, r.sent_usec};
        // microsecond borrow
        if (r.now_usec < r.sent_usec) begin
          secs  = secs - 1;
          usecs = usecs + ert_pkg::USEC_PER_SEC;
        end
        trip = secs * ert_pkg::USEC_PER_SEC + usecs;
        t.trip_time = trip;
        wide_sum = {1'b0, time_sum} + trip;
        time_sum = wide_sum[ert_pkg::SUM_W] ? '1 : wide_sum[ert_pkg::SUM_W-1:0];
        if (trip < least_us) least_us = trip;
        if (trip > most_us) most_us = trip;
        slot = int'(r.reply_seq) % ert_pkg::SEEN_DEPTH;
        if (seen_slots[slot]) begin
          dup_count = dup_count + 1;
          t.status = ert_pkg::ST_DUP;
        end else begin
          seen_slots[slot] = 1'b1;
          fresh_count = fresh_count + 1;
          t.status = ert_pkg::ST_NEW;
        end
      end else if (r.reply_kind == ert_pkg::KIND_ECHO_REQUEST) begin
        t.status = ert_pkg::ST_OWN_REQ;
      end else begin
        t.status = ert_pkg::ST_OTHER;
      end
    end else begin
      t.status = ert_pkg::ST_OK;
      if (fresh_count == 0) begin
        t.avg_time = ert_pkg::NO_AVERAGE;
      end else begin
        den = {1'b0, fresh_count} + {1'b0, dup_count};
        quo = time_sum / den;
        t.avg_time = (|quo[ert_pkg::SUM_W-1:ert_pkg::TIME_W]) ? '1
                                                              : quo[ert_pkg::TIME_W-1:0];
      end
    end
    t.sent_total      = sends_made;
    t.received_total  = fresh_count;
    t.duplicate_total = dup_count;
    t.min_time        = least_us;
    t.max_time        = most_us;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------
  function automatic req_t plain_beat(input logic [ert_pkg::REQ_W-1:0] kind_of_req);
    req_t b;
    b = '0;
    b.req_type = kind_of_req;
    return b;
  endfunction

  function automatic req_t send_beat();
    gen_sends++;
    return plain_beat(ert_pkg::REQ_SEND);
  endfunction

  function automatic req_t reply_beat(input logic [ert_pkg::LEN_W-1:0] len,
                                      input logic [ert_pkg::LEN_W-1:0] id,
                                      input logic [ert_pkg::KIND_W-1:0] kind,
                                      input logic [ert_pkg::SEQ_W-1:0] sq,
                                      input logic [ert_pkg::SEC_W-1:0] ss,
                                      input logic [ert_pkg::USEC_W-1:0] su,
                                      input logic [ert_pkg::SEC_W-1:0] ns,
                                      input logic [ert_pkg::USEC_W-1:0] nu);
    req_t b;
    b = plain_beat(ert_pkg::REQ_REPLY);
    b.reply_length = len;
    b.reply_id     = id;
    b.reply_kind   = kind;
    b.reply_seq    = sq;
    b.sent_sec     = ss;
    b.sent_usec    = su;
    b.now_sec      = ns;
    b.now_usec     = nu;
    return b;
  endfunction

  // Mostly well-formed ping traffic (sends, replies to recent sequences, reports),
  // the rest noise: short, foreign, wrong type, unused request, fully random.
  function automatic req_t compose_request();
    req_t b;
    int pick, thr, back, len;
    longint unsigned span;
    logic [ert_pkg::KIND_W-1:0] k;
    b.reply_length = 16'($urandom);
    b.reply_id     = 16'($urandom);
    b.reply_kind   = 8'($urandom);
    b.reply_seq    = 16'($urandom);
    b.sent_sec     = $urandom;
    b.sent_usec    = 20'($urandom);
    b.now_sec      = $urandom;
    b.now_usec     = 20'($urandom);
    thr  = int'(min_payload) + 8;
    pick = $urandom_range(99);
    if (pick < 34) begin
      gen_sends++;
      b.req_type = ert_pkg::REQ_SEND;
    end else if (pick < 74) begin
      b.req_type   = ert_pkg::REQ_REPLY;
      b.reply_id   = own_ident;
      b.reply_kind = ert_pkg::KIND_ECHO_REPLY;
      if (thr <= 65535) begin
        len = ($urandom_range(7) == 0) ? thr : thr + $urandom_range(40);
        b.reply_length = 16'((len > 65535) ? 65535 : len);
      end
      if (gen_sends != 0 && $urandom_range(9) != 0) begin
        back = $urandom_range((gen_sends > 7) ? 6 : gen_sends - 1);
        b.reply_seq = 16'(gen_sends - 1 - back);
      end
      b.sent_usec = 20'($urandom_range(999999));
      span = ($urandom_range(15) == 0) ? longint'($urandom) : longint'($urandom_range(2500000));
      span += b.sent_usec;
      b.now_usec = 20'(span % 1000000);
      b.now_sec  = b.sent_sec + 32'(span / 1000000);
    end else if (pick < 82) begin
      b.req_type = ert_pkg::REQ_REPORT;
    end else begin
      b.req_type   = ert_pkg::REQ_REPLY;
      b.reply_id   = own_ident;
      b.reply_kind = ert_pkg::KIND_ECHO_REPLY;
      if (thr <= 65535) b.reply_length = 16'(thr);
      case ($urandom_range(5))
        0: b.reply_length = 16'($urandom_range((thr > 65536) ? 65535 : thr - 1));
        1: b.reply_id = own_ident ^ 16'($urandom_range(65535, 1));
        2: b.reply_kind = ert_pkg::KIND_ECHO_REQUEST;
        3: begin
          k = 8'($urandom_range(255, 1));
          b.reply_kind = (k == ert_pkg::KIND_ECHO_REQUEST) ? 8'hFF : k;
        end
        4: b.req_type = ert_pkg::REQ_NONE;
        default: begin
          b.reply_length = 16'($urandom);
          b.reply_id     = 16'($urandom);
          b.reply_kind   = 8'($urandom);
        end
      endcase
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: offers queued beats, predicts each one as it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tally_t t;
    bit     yields;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        t = tally_request(offer, yields);
        if (yields) awaited_tallies.push_back(t);
        beats_taken++;
      end
      // slot is free after this edge: offer the next beat, or idle
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          offer    <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result ready: random stalls plus long hold-offs on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int hold_left;
    int hold_taken;
    if (hold_asks != hold_taken) begin
      hold_taken = hold_asks;
      hold_left  = HOLD_SPAN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every taken result against the oldest prediction.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] result %0d: %s expected %0h, got %0h", $realtime, results_seen,
                 name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    tally_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      status_hits[out_status]++;
      if (awaited_tallies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result beat with nothing expected: status %0d seq %0h",
                   $realtime, out_status, out_seq_out);
      end else begin
        want = awaited_tallies.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("seq_out", 32'(want.seq_out), 32'(out_seq_out));
        check_field("trip_time", want.trip_time, out_trip_time);
        check_field("sent_total", want.sent_total, out_sent_total);
        check_field("received_total", want.received_total, out_received_total);
        check_field("duplicate_total", want.duplicate_total, out_duplicate_total);
        check_field("min_time", want.min_time, out_min_time);
        check_field("max_time", want.max_time, out_max_time);
        check_field("avg_time", want.avg_time, out_avg_time);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles,
               awaited_tallies.size());
      $display("echo_reply_tracker_top_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  // Register write; only issued while the block is idle, so the shadow copy follows at once.
  task automatic write_reg(input logic [ert_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ert_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ert_pkg::CFG_OWN_ID) own_ident = val;
    else min_payload = val;
  endtask

  // Sender pauses until everything queued is taken and answered, then lets
  // an ignored beat's processing finish.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || awaited_tallies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [ert_pkg::CFG_DATA_W-1:0] id,
                           input logic [ert_pkg::CFG_DATA_W-1:0] plen,
                           input int beats, input int idle, input bit hold);
    write_reg(ert_pkg::CFG_OWN_ID, id);
    write_reg(ert_pkg::CFG_PAYLOAD_LEN, plen);
    settings_run++;
    idle_pct = idle;
    repeat (beats) pending_requests.push_back(compose_request());
    if (hold) hold_asks++;
    wait_drained();
  endtask

  initial begin
    req_t odd;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: id 0, 56-byte payload, so the shortest accepted reply is 64 bytes.
    // Registers go in while the bitmap clear pass runs.
    write_reg(ert_pkg::CFG_OWN_ID, 16'h0000);
    write_reg(ert_pkg::CFG_PAYLOAD_LEN, 16'd56);
    settings_run++;
    pending_requests.push_back(plain_beat(ert_pkg::REQ_REPORT));  // nothing received yet
    // reply to a sequence before it was sent; its send later clears the slot
    pending_requests.push_back(reply_beat(16'd64, 16'h0000, ert_pkg::KIND_ECHO_REPLY, 16'd4,
                                          32'd10, 20'd0, 32'd10, 20'd500));
    pending_requests.push_back(send_beat());
    pending_requests.push_back(send_beat());
    pending_requests.push_back(reply_beat(16'd64, 16'h0000, ert_pkg::KIND_ECHO_REPLY, 16'd0,
                                          32'd100, 20'd250000, 32'd100, 20'd750000));
    // duplicate
    pending_requests.push_back(reply_beat(16'd64, 16'h0000, ert_pkg::KIND_ECHO_REPLY, 16'd0,
                                          32'd100, 20'd250000, 32'd101, 20'd0));
    // borrow
    pending_requests.push_back(reply_beat(16'd1500, 16'h0000, ert_pkg::KIND_ECHO_REPLY, 16'd1,
                                          32'd5, 20'd900000, 32'd7, 20'd100000));
    // too short
    pending_requests.push_back(reply_beat(16'd63, 16'h0000, ert_pkg::KIND_ECHO_REPLY, 16'd1,
                                          32'd0, 20'd0, 32'd1, 20'd0));
    // foreign
    pending_requests.push_back(reply_beat(16'hFFFF, 16'hFFFF, ert_pkg::KIND_ECHO_REPLY, 16'd1,
                                          32'd0, 20'd0, 32'd1, 20'd0));
    pending_requests.push_back(reply_beat(16'd64, 16'h0000, ert_pkg::KIND_ECHO_REQUEST, 16'd1,
                                          32'd0, 20'd0, 32'd1, 20'd0));
    pending_requests.push_back(reply_beat(16'd64, 16'h0000, 8'hFF, 16'd1,
                                          32'd0, 20'd0, 32'd1, 20'd0));
    odd = '1;
    odd.req_type = ert_pkg::REQ_NONE;                     // ignored, no result
    pending_requests.push_back(odd);
    // sequence 1024 lands on slot 0, already seen
    pending_requests.push_back(reply_beat(16'd64, 16'h0000, ert_pkg::KIND_ECHO_REPLY, 16'd1024,
                                          32'd20, 20'd0, 32'd20, 20'd30));
    // seconds wrap from all ones to zero with a borrow: one microsecond
    pending_requests.push_back(reply_beat(16'd64, 16'h0000, ert_pkg::KIND_ECHO_REPLY, 16'hFFFF,
                                          32'hFFFF_FFFF, 20'd999999, 32'd0, 20'd0));
    // arrival before the send
    pending_requests.push_back(reply_beat(16'd64, 16'h0000, ert_pkg::KIND_ECHO_REPLY, 16'd2,
                                          32'd1000, 20'd0, 32'd10, 20'd500000));
    // microseconds beyond a second, both directions
    pending_requests.push_back(reply_beat(16'd64, 16'h0000, ert_pkg::KIND_ECHO_REPLY, 16'd3,
                                          32'd50, 20'hFFFFF, 32'd50, 20'd0));
    pending_requests.push_back(reply_beat(16'd64, 16'h0000, ert_pkg::KIND_ECHO_REPLY, 16'd5,
                                          32'd50, 20'd0, 32'd50, 20'hFFFFF));
    pending_requests.push_back(plain_beat(ert_pkg::REQ_REPORT));
    pending_requests.push_back(send_beat());
    pending_requests.push_back(send_beat());
    pending_requests.push_back(send_beat());              // seq 4: clears its slot
    // new again
    pending_requests.push_back(reply_beat(16'd64, 16'h0000, ert_pkg::KIND_ECHO_REPLY, 16'd4,
                                          32'd60, 20'd0, 32'd60, 20'd77));
    pending_requests.push_back(plain_beat(ert_pkg::REQ_REPORT));
    wait_drained();

    // Random phases over several register settings, extremes included.
    run_phase(16'hBEEF, 16'd56, 380, 13, 1'b1);           // long receiver hold-off
    run_phase(16'hFFFF, 16'd0, 260, 0, 1'b0);             // no idling at all
    run_phase(16'h0000, 16'hFFFF, 40, 13, 1'b0);          // every reply too short
    run_phase(16'h5A3C, 16'd1472, 220, 13, 1'b0);
    run_phase(16'($urandom), 16'($urandom_range(1500)), 250, 13, 1'b1);

    $display("covered %0d request beats and %0d results over %0d register settings",
             beats_taken, results_seen, settings_run);
    $display("status mix: ok %0d short %0d foreign %0d new %0d dup %0d own-req %0d other %0d",
             status_hits[ert_pkg::ST_OK], status_hits[ert_pkg::ST_SHORT],
             status_hits[ert_pkg::ST_FOREIGN], status_hits[ert_pkg::ST_NEW],
             status_hits[ert_pkg::ST_DUP], status_hits[ert_pkg::ST_OWN_REQ],
             status_hits[ert_pkg::ST_OTHER]);
    if (mismatches == 0) begin
      $display("echo_reply_tracker_top_tb: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("echo_reply_tracker_top_tb: FAIL");
    end
    $finish;
  end

endmodule
